// ===== design/kjcm_pkg.sv =====
// Package for the key/joystick control mapper.
// Holds the item structs, request and register codes and fixed scan codes.
// No dependencies.
package kjcm_pkg;

    localparam int AXIS_W        = 16;   // joystick axis width
    localparam int CTRL_W        = 8;    // width of the controls and taps fields
    localparam int CTRL_BITS_DEF = 8;    // default number of bound control bits
    localparam int MENU_W        = 5;
    localparam int CODE_W        = 7;
    localparam int SHIFT_W       = 2;
    localparam int JOY_W         = 6;
    localparam int BIND_W        = 8;    // one scan-code byte per binding
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int DEAD_SHIFT    = 3;    // dead zone is range / 8

    // Fixed scan codes
    localparam logic [CODE_W-1:0] CODE_LSHIFT = 7'd42;
    localparam logic [CODE_W-1:0] CODE_RSHIFT = 7'd54;
    localparam logic [CODE_W-1:0] CODE_UP     = 7'd72;
    localparam logic [CODE_W-1:0] CODE_DOWN   = 7'd80;
    localparam logic [CODE_W-1:0] CODE_LEFT   = 7'd75;
    localparam logic [CODE_W-1:0] CODE_RIGHT  = 7'd77;
    localparam logic [CODE_W-1:0] CODE_ENTER  = 7'd28;

    // Bit positions shared by joystick and menu bits
    localparam int BIT_UP = 0;
    localparam int BIT_DN = 1;
    localparam int BIT_LF = 2;
    localparam int BIT_RT = 3;
    localparam int BIT_B1 = 4;
    localparam int BIT_B2 = 5;

    // Reset values
    localparam logic [AXIS_W-1:0] CENTER_RST = 16'd32767;
    localparam logic [AXIS_W-1:0] MIN_RST    = 16'd0;
    localparam logic [AXIS_W-1:0] MAX_RST    = 16'd65535;

    typedef enum logic [1:0] {
        REQ_KEY_DOWN = 2'd0,
        REQ_KEY_UP   = 2'd1,
        REQ_JOY      = 2'd2,
        REQ_STATUS   = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_BINDINGS = 3'd0,
        REG_JOY_ENABLE   = 3'd1,
        REG_CENTER_X     = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_START_MIN_X  = 3'd4,
        REG_START_MAX_X  = 3'd5,
        REG_START_MIN_Y  = 3'd6,
        REG_START_MAX_Y  = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        t_req                req_type;
        logic [CODE_W-1:0]   scan_code;
        logic [AXIS_W-1:0]   joy_x;
        logic [AXIS_W-1:0]   joy_y;
        logic [1:0]          joy_buttons;
        logic                joy_valid;
        logic                clear_taps;
        logic                clear_arrow_taps;
        logic                clear_scan_code;
    } t_in;

    typedef struct packed {
        logic [CTRL_W-1:0]   controls;
        logic [CTRL_W-1:0]   taps;
        logic [MENU_W-1:0]   arrows;
        logic [MENU_W-1:0]   arrow_taps;
        logic [CODE_W-1:0]   last_code;
        logic [SHIFT_W-1:0]  shift_bits;
    } t_out;

endpackage

// ===== design/key_joystick_control_mapper_top.sv =====
// Top level of the key/joystick control mapper: input stage, update logic, result register.
// Depends on kjcm_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_ready, i_in_data): one item is a key down, key up,
//   joystick sample or status read, together with three read-and-clear flags.
//   Output channel (o_out_valid / i_out_ready, o_out_data): exactly one result item per
//   input item, in order.
//   Configuration (i_cfg_we, i_cfg_index, i_cfg_data): plain write, no wait. Write only
//   while the block is idle. Writing a start_* register also reloads the matching
//   range end.
//   Flow: an accepted item waits in the input register until the result register is
//   free or being emptied; then state and result are updated together.
//   Throughput: one item per cycle while the receiver keeps i_out_ready high. The only
//   loop is the state update itself, so items follow back to back.
//   Stall: when the receiver holds i_out_ready low, the result register keeps its item
//   and the input register still takes one more item; after that o_in_ready drops
//   until the result is taken.
//   Reset (i_rst_n low, synchronous): both stages empty, held/tap/menu/shift/code state
//   cleared, configuration and calibration ranges back to their defaults.
module key_joystick_control_mapper_top #(
    parameter int CONTROL_BITS = kjcm_pkg::CTRL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  kjcm_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output kjcm_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [kjcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kjcm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import kjcm_pkg::*;

    typedef struct packed {
        logic [AXIS_W-1:0] mn;
        logic [AXIS_W-1:0] mx;
        logic              lo;
        logic              hi;
    } t_axis;

    // Widen the range with pos, then compare pos - ctr against +/- (range / 8),
    // range / 8 truncated toward zero when the range is inverted.
    function automatic t_axis axis_eval(
        input logic [AXIS_W-1:0] pos,
        input logic [AXIS_W-1:0] mn,
        input logic [AXIS_W-1:0] mx,
        input logic [AXIS_W-1:0] ctr
    );
        t_axis                    r;
        logic signed [AXIS_W:0]   diff;
        logic signed [AXIS_W:0]   dead;
        logic signed [AXIS_W+1:0] d_e;
        logic signed [AXIS_W+1:0] o_e;
        r.mn = (pos < mn) ? pos : mn;
        r.mx = (pos > mx) ? pos : mx;
        diff = $signed({1'b0, r.mx}) - $signed({1'b0, r.mn});
        if (diff < 0) begin
            dead = (diff + $signed((AXIS_W+1)'(7))) >>> DEAD_SHIFT;
        end else begin
            dead = diff >>> DEAD_SHIFT;
        end
        d_e  = (AXIS_W+2)'(dead);
        o_e  = $signed({2'b00, pos}) - $signed({2'b00, ctr});
        r.lo = (o_e < -d_e);
        r.hi = (o_e > d_e);
        return r;
    endfunction

    // Configuration
    logic [CONTROL_BITS-1:0][BIND_W-1:0] r_bind;
    logic                                r_joy_en;
    logic [AXIS_W-1:0]                   r_ctr_x, r_ctr_y;

    // Mapper state
    logic [CONTROL_BITS-1:0] r_held, n_held;
    logic [CTRL_W-1:0]       r_tap, n_tap;
    logic [MENU_W-1:0]       r_menu, n_menu;
    logic [MENU_W-1:0]       r_menu_tap, n_menu_tap;
    logic [SHIFT_W-1:0]      r_shift, n_shift;
    logic [CODE_W-1:0]       r_code, n_code;
    logic [JOY_W-1:0]        r_joy_prev, n_joy_prev;
    logic [AXIS_W-1:0]       r_min_x, r_max_x, r_min_y, r_max_y;
    logic [AXIS_W-1:0]       n_min_x, n_max_x, n_min_y, n_max_y;

    // Pipeline
    logic r_s1_valid;
    t_in  r_s1_data;
    logic r_out_valid;
    t_out r_out_data, n_out_data;
    logic advance;

    // Decoded key and joystick terms
    logic [CONTROL_BITS-1:0] match;
    logic [MENU_W-1:0]       menu_m;
    logic [SHIFT_W-1:0]      shift_m;
    logic                    take_sample;
    t_axis                   ax_x, ax_y;
    logic [JOY_W-1:0]        joy_st;
    logic [JOY_W-1:0]        joy_seen;

    // Move the held item on when the result register is free or being emptied
    assign advance     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        for (int n = 0; n < CONTROL_BITS; n++) begin
            match[n] = (r_bind[n] == {1'b0, r_s1_data.scan_code});
        end
        menu_m          = '0;
        menu_m[BIT_UP]  = (r_s1_data.scan_code == CODE_UP);
        menu_m[BIT_DN]  = (r_s1_data.scan_code == CODE_DOWN);
        menu_m[BIT_LF]  = (r_s1_data.scan_code == CODE_LEFT);
        menu_m[BIT_RT]  = (r_s1_data.scan_code == CODE_RIGHT);
        menu_m[BIT_B1]  = (r_s1_data.scan_code == CODE_ENTER);
        shift_m[0]      = (r_s1_data.scan_code == CODE_LSHIFT);
        shift_m[1]      = (r_s1_data.scan_code == CODE_RSHIFT);

        ax_x = axis_eval(r_s1_data.joy_x, r_min_x, r_max_x, r_ctr_x);
        ax_y = axis_eval(r_s1_data.joy_y, r_min_y, r_max_y, r_ctr_y);
        joy_st         = '0;
        joy_st[BIT_LF] = ax_x.lo;
        joy_st[BIT_RT] = ax_x.hi;
        joy_st[BIT_UP] = ax_y.lo;
        joy_st[BIT_DN] = ax_y.hi;
        joy_st[BIT_B1] = r_s1_data.joy_buttons[0];
        joy_st[BIT_B2] = r_s1_data.joy_buttons[1];
        take_sample = (r_s1_data.req_type == REQ_JOY) && r_s1_data.joy_valid && r_joy_en;
    end

    // Apply the request, report, then clear under the item's flags
    always_comb begin
        n_held     = r_held;
        n_tap      = r_tap;
        n_menu     = r_menu;
        n_menu_tap = r_menu_tap;
        n_shift    = r_shift;
        n_code     = r_code;
        n_joy_prev = r_joy_prev;
        n_min_x    = r_min_x;
        n_max_x    = r_max_x;
        n_min_y    = r_min_y;
        n_max_y    = r_max_y;

        unique case (r_s1_data.req_type)
            REQ_KEY_DOWN: begin
                n_code     = r_s1_data.scan_code;
                n_shift    = r_shift | shift_m;
                n_held     = r_held | match;
                n_tap      = r_tap | CTRL_W'(match);
                n_menu     = r_menu | menu_m;
                n_menu_tap = r_menu_tap | menu_m;
            end
            REQ_KEY_UP: begin
                n_shift = r_shift & ~shift_m;
                n_held  = r_held & ~match;
                n_menu  = r_menu & ~menu_m;
            end
            REQ_JOY: begin
                if (take_sample) begin
                    n_min_x    = ax_x.mn;
                    n_max_x    = ax_x.mx;
                    n_min_y    = ax_y.mn;
                    n_max_y    = ax_y.mx;
                    n_tap      = r_tap | CTRL_W'(joy_st & ~r_joy_prev);
                    n_joy_prev = joy_st;
                end
            end
            REQ_STATUS: begin
                // report and clear only
            end
            default: begin
            end
        endcase

        joy_seen = r_joy_en ? n_joy_prev : '0;
        n_out_data.controls   = CTRL_W'(n_held) | CTRL_W'(joy_seen);
        n_out_data.taps       = n_tap;
        n_out_data.arrows     = n_menu;
        n_out_data.arrow_taps = n_menu_tap;
        n_out_data.last_code  = n_code;
        n_out_data.shift_bits = n_shift;

        if (r_s1_data.clear_taps) begin
            n_tap = '0;
        end
        if (r_s1_data.clear_arrow_taps) begin
            n_menu_tap = '0;
        end
        if (r_s1_data.clear_scan_code) begin
            n_code = '0;
        end
    end

    // Control, configuration and mapper state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bind      <= '0;
            r_joy_en    <= 1'b1;
            r_ctr_x     <= CENTER_RST;
            r_ctr_y     <= CENTER_RST;
            r_held      <= '0;
            r_tap       <= '0;
            r_menu      <= '0;
            r_menu_tap  <= '0;
            r_shift     <= '0;
            r_code      <= '0;
            r_joy_prev  <= '0;
            r_min_x     <= MIN_RST;
            r_max_x     <= MAX_RST;
            r_min_y     <= MIN_RST;
            r_max_y     <= MAX_RST;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                r_held     <= n_held;
                r_tap      <= n_tap;
                r_menu     <= n_menu;
                r_menu_tap <= n_menu_tap;
                r_shift    <= n_shift;
                r_code     <= n_code;
                r_joy_prev <= n_joy_prev;
                r_min_x    <= n_min_x;
                r_max_x    <= n_max_x;
                r_min_y    <= n_min_y;
                r_max_y    <= n_max_y;
            end

            // Users must write only while idle (unenforced); range reloads win over updates
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_KEY_BINDINGS: r_bind   <= i_cfg_data[BIND_W*CONTROL_BITS-1:0];
                    REG_JOY_ENABLE:   r_joy_en <= i_cfg_data[0];
                    REG_CENTER_X:     r_ctr_x  <= i_cfg_data[AXIS_W-1:0];
                    REG_CENTER_Y:     r_ctr_y  <= i_cfg_data[AXIS_W-1:0];
                    REG_START_MIN_X:  r_min_x  <= i_cfg_data[AXIS_W-1:0];
                    REG_START_MAX_X:  r_max_x  <= i_cfg_data[AXIS_W-1:0];
                    REG_START_MIN_Y:  r_min_y  <= i_cfg_data[AXIS_W-1:0];
                    REG_START_MAX_Y:  r_max_y  <= i_cfg_data[AXIS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    // Calibration only widens: minimum never rises without a configuration write
    a_min_x_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cfg_we)) |-> (r_min_x <= $past(r_min_x)))
        else $error("x range minimum rose without a configuration write");

    a_max_y_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cfg_we)) |-> (r_max_y >= $past(r_max_y)))
        else $error("y range maximum fell without a configuration write");

    // Tap state moves only when an item is processed
    a_tap_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_tap))
        else $error("tap bits changed with no item processed");

    // A result appears only after an item sat in the input stage
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result valid without a held input item");
`endif

endmodule

// ===== bench/kjcm_bench_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the key/joystick control mapper bench: predicts each result item
// from its own copy of the mapper state and checks the items that come out.
// Depends on kjcm_pkg.
package kjcm_bench_pkg;

    import kjcm_pkg::*;

    class control_map_scoreboard;

        // Configuration copy
        logic [CFG_DATA_W-1:0] bindings;
        logic                  joy_en;
        logic [AXIS_W-1:0]     ctr_x;
        logic [AXIS_W-1:0]     ctr_y;

        // Mapper state copy
        logic [CTRL_W-1:0]     held;
        logic [CTRL_W-1:0]     taps;
        logic [MENU_W-1:0]     menu_held;
        logic [MENU_W-1:0]     menu_taps;
        logic [SHIFT_W-1:0]    shift_held;
        logic [CODE_W-1:0]     last_code;
        logic [JOY_W-1:0]      joy_prev;
        logic [AXIS_W-1:0]     lo_x;
        logic [AXIS_W-1:0]     hi_x;
        logic [AXIS_W-1:0]     lo_y;
        logic [AXIS_W-1:0]     hi_y;

        t_out                  pending_reports[$];
        int                    mismatches;

        function new();
            bindings   = '0;
            joy_en     = 1'b1;
            ctr_x      = CENTER_RST;
            ctr_y      = CENTER_RST;
            held       = '0;
            taps       = '0;
            menu_held  = '0;
            menu_taps  = '0;
            shift_held = '0;
            last_code  = '0;
            joy_prev   = '0;
            lo_x       = MIN_RST;
            hi_x       = MAX_RST;
            lo_y       = MIN_RST;
            hi_y       = MAX_RST;
            mismatches = 0;
        endfunction

        // Start registers reload the tracked range end as well.
        function void load_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_KEY_BINDINGS: bindings = value;
                REG_JOY_ENABLE:   joy_en   = value[0];
                REG_CENTER_X:     ctr_x    = value[AXIS_W-1:0];
                REG_CENTER_Y:     ctr_y    = value[AXIS_W-1:0];
                REG_START_MIN_X:  lo_x     = value[AXIS_W-1:0];
                REG_START_MAX_X:  hi_x     = value[AXIS_W-1:0];
                REG_START_MIN_Y:  lo_y     = value[AXIS_W-1:0];
                REG_START_MAX_Y:  hi_y     = value[AXIS_W-1:0];
                default: ;
            endcase
        endfunction

        // A binding byte above 127 can never equal a zero-extended code.
        function logic [CTRL_W-1:0] bound_bits(input logic [CODE_W-1:0] code);
            logic [CTRL_W-1:0] bits;
            bits = '0;
            for (int n = 0; n < CTRL_BITS_DEF; n++) begin
                if (bindings[n*BIND_W +: BIND_W] == {1'b0, code})
                    bits[n] = 1'b1;
            end
            return bits;
        endfunction

        function logic [MENU_W-1:0] menu_bits(input logic [CODE_W-1:0] code);
            logic [MENU_W-1:0] bits;
            bits = '0;
            case (code)
                CODE_UP:    bits[BIT_UP] = 1'b1;
                CODE_DOWN:  bits[BIT_DN] = 1'b1;
                CODE_LEFT:  bits[BIT_LF] = 1'b1;
                CODE_RIGHT: bits[BIT_RT] = 1'b1;
                CODE_ENTER: bits[BIT_B1] = 1'b1;
                default: ;
            endcase
            return bits;
        endfunction

        function logic [SHIFT_W-1:0] shift_of(input logic [CODE_W-1:0] code);
            if (code == CODE_LSHIFT) return 2'b01;
            if (code == CODE_RSHIFT) return 2'b10;
            return 2'b00;
        endfunction

        // Widen the range, then compare against the centre. An inverted range gives
        // a negative dead zone, truncated toward zero.
        function void track_axis(input logic [AXIS_W-1:0] pos, input logic [AXIS_W-1:0] ctr,
                                 inout logic [AXIS_W-1:0] mn, inout logic [AXIS_W-1:0] mx,
                                 output logic below, output logic above);
            longint span_hi;
            longint span_lo;
            longint dead;
            longint off;
            if (pos < mn) mn = pos;
            if (pos > mx) mx = pos;
            span_hi = mx;
            span_lo = mn;
            dead    = (span_hi - span_lo) / (1 << DEAD_SHIFT);
            off     = longint'(pos) - longint'(ctr);
            below   = (off < -dead);
            above   = (off > dead);
        endfunction

        function void note_item(input t_in item);
            t_out              rep;
            logic [CTRL_W-1:0] keys;
            logic [MENU_W-1:0] menu;
            logic [SHIFT_W-1:0] sh;
            logic [JOY_W-1:0]  now;
            logic [JOY_W-1:0]  fresh;
            logic [CTRL_W-1:0] joy_word;
            logic              below;
            logic              above;
            keys = bound_bits(item.scan_code);
            menu = menu_bits(item.scan_code);
            sh   = shift_of(item.scan_code);
            case (item.req_type)
                REQ_KEY_DOWN: begin
                    last_code  = item.scan_code;
                    shift_held = shift_held | sh;
                    held       = held | keys;
                    taps       = taps | keys;
                    menu_held  = menu_held | menu;
                    menu_taps  = menu_taps | menu;
                end
                REQ_KEY_UP: begin
                    shift_held = shift_held & ~sh;
                    held       = held & ~keys;
                    menu_held  = menu_held & ~menu;
                end
                REQ_JOY: begin
                    if (item.joy_valid && joy_en) begin
                        now = '0;
                        track_axis(item.joy_x, ctr_x, lo_x, hi_x, below, above);
                        now[BIT_LF] = below;
                        now[BIT_RT] = above;
                        track_axis(item.joy_y, ctr_y, lo_y, hi_y, below, above);
                        now[BIT_UP] = below;
                        now[BIT_DN] = above;
                        now[BIT_B1] = item.joy_buttons[0];
                        now[BIT_B2] = item.joy_buttons[1];
                        fresh    = now & ~joy_prev;
                        taps     = taps | {{(CTRL_W-JOY_W){1'b0}}, fresh};
                        joy_prev = now;
                    end
                end
                default: ;
            endcase
            joy_word = '0;
            if (joy_en) joy_word[JOY_W-1:0] = joy_prev;
            rep.controls   = held | joy_word;
            rep.taps       = taps;
            rep.arrows     = menu_held;
            rep.arrow_taps = menu_taps;
            rep.last_code  = last_code;
            rep.shift_bits = shift_held;
            pending_reports.push_back(rep);
            // Read-and-clear happens after the report is taken.
            if (item.clear_taps)       taps      = '0;
            if (item.clear_arrow_taps) menu_taps = '0;
            if (item.clear_scan_code)  last_code = '0;
        endfunction

        function void check_item(input t_out got);
            t_out want;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %0d: result item with nothing expected (%h)",
                             mismatches, got);
                return;
            end
            want = pending_reports.pop_front();
            if (got.controls !== want.controls || got.taps !== want.taps ||
                got.arrows !== want.arrows || got.arrow_taps !== want.arrow_taps ||
                got.last_code !== want.last_code || got.shift_bits !== want.shift_bits) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch %0d (expected/actual): controls %h/%h taps %h/%h ",
                              "arrows %h/%h arrow_taps %h/%h last_code %h/%h shift %h/%h"},
                             mismatches, want.controls, got.controls, want.taps, got.taps,
                             want.arrows, got.arrows, want.arrow_taps, got.arrow_taps,
                             want.last_code, got.last_code, want.shift_bits, got.shift_bits);
            end
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function bit clean();
            return (mismatches == 0) && (pending_reports.size() == 0);
        endfunction

    endclass

endpackage

// ===== bench/key_joystick_control_mapper_top_tb.sv =====
`timescale 1ns / 100ps
// Top of the key/joystick control mapper bench: clock, reset, stimulus and the watchdog.
// Depends on kjcm_pkg, kjcm_bench_pkg and key_joystick_control_mapper_top.
module key_joystick_control_mapper_top_tb;

    import kjcm_pkg::*;
    import kjcm_bench_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no item moving on either side
    localparam int SETTLE_CYCLES  = 4;      // margin after the last expected result

    // Read-and-clear flag groups: {taps, arrow taps, scan code}
    localparam logic [2:0] CLR_NONE = 3'b000;
    localparam logic [2:0] CLR_TAPS = 3'b100;
    localparam logic [2:0] CLR_CODE = 3'b001;
    localparam logic [2:0] CLR_ALL  = 3'b111;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   out_ready = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    t_in                    in_data   = '0;
    logic                   in_ready;
    logic                   out_valid;
    t_out                   out_data;

    control_map_scoreboard  sb;

    // Stimulus knobs shared with the receiver
    int                     idle_pct   = 0;
    int                     stall_left = 0;
    int                     quiet_cnt  = 0;
    logic [CFG_DATA_W-1:0]  cur_bindings = '0;
    logic [AXIS_W-1:0]      cur_cx = CENTER_RST;
    logic [AXIS_W-1:0]      cur_cy = CENTER_RST;

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD/2) clk = ~clk;
    end

    key_joystick_control_mapper_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Monitor: everything here reads the values from before the edge, so
    // an item counts as moved exactly when valid and ready were both high.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            sb.note_item(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_item(out_data);
    end

    // Watchdog: restart the count whenever an item moves on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("key_joystick_control_mapper_top regression: fail");
            $finish;
        end
    end

    // Receiver: drop ready for bursts of random length, at the current idle rate.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            out_ready  <= 1'b1;
        end
    end

    function automatic t_in make_item(input t_req req, input logic [CODE_W-1:0] code,
                                      input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                                      input logic [1:0] btn, input logic ok,
                                      input logic [2:0] clr);
        t_in it;
        it.req_type         = req;
        it.scan_code        = code;
        it.joy_x            = x;
        it.joy_y            = y;
        it.joy_buttons      = btn;
        it.joy_valid        = ok;
        it.clear_taps       = clr[2];
        it.clear_arrow_taps = clr[1];
        it.clear_scan_code  = clr[0];
        return it;
    endfunction

    // Random item: key codes lean towards bound and fixed codes so that
    // matches, menu bits and shifts happen often; joystick positions lean
    // towards the centre so the dead zone edges are crossed both ways.
    function automatic t_in random_item();
        t_in         it;
        int          pick;
        int          offset;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        pick = $urandom_range(0, 99);
        if (pick < 35)      it.req_type = REQ_KEY_DOWN;
        else if (pick < 60) it.req_type = REQ_KEY_UP;
        else if (pick < 90) it.req_type = REQ_JOY;
        else                it.req_type = REQ_STATUS;

        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            it.scan_code = cur_bindings[8*$urandom_range(0, 7) +: CODE_W];
        end else if (pick < 75) begin
            case ($urandom_range(0, 6))
                0:       it.scan_code = CODE_UP;
                1:       it.scan_code = CODE_DOWN;
                2:       it.scan_code = CODE_LEFT;
                3:       it.scan_code = CODE_RIGHT;
                4:       it.scan_code = CODE_ENTER;
                5:       it.scan_code = CODE_LSHIFT;
                default: it.scan_code = CODE_RSHIFT;
            endcase
        end else begin
            it.scan_code = CODE_W'($urandom_range(0, 127));
        end

        raw_x = 16'($urandom_range(0, 65535));
        raw_y = 16'($urandom_range(0, 65535));
        pick  = $urandom_range(0, 99);
        if (pick < 50) begin
            offset  = $urandom_range(0, 18000);
            raw_x   = cur_cx + 16'(offset - 9000);
            offset  = $urandom_range(0, 18000);
            raw_y   = cur_cy + 16'(offset - 9000);
        end else if (pick < 60) begin
            raw_x = $urandom_range(0, 1) ? MAX_RST : MIN_RST;
            raw_y = $urandom_range(0, 1) ? MAX_RST : MIN_RST;
        end
        it.joy_x            = raw_x;
        it.joy_y            = raw_y;
        it.joy_buttons      = 2'($urandom_range(0, 3));
        it.joy_valid        = ($urandom_range(0, 99) < 85);
        it.clear_taps       = ($urandom_range(0, 99) < 30);
        it.clear_arrow_taps = ($urandom_range(0, 99) < 30);
        it.clear_scan_code  = ($urandom_range(0, 99) < 30);
        return it;
    endfunction

    // Offer one item, after an optional idle burst, and hold it until accepted.
    task automatic send_item(input t_in item);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait for every expected result, then let the pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.load_reg(idx, value);
        @(posedge clk);
    endtask

    // Write the whole register set; only ever called with the block idle.
    task automatic configure(input logic [CFG_DATA_W-1:0] binds, input logic en,
                             input logic [AXIS_W-1:0] cx, input logic [AXIS_W-1:0] cy,
                             input logic [AXIS_W-1:0] mnx, input logic [AXIS_W-1:0] mxx,
                             input logic [AXIS_W-1:0] mny, input logic [AXIS_W-1:0] mxy);
        write_reg(REG_KEY_BINDINGS, binds);
        write_reg(REG_JOY_ENABLE,   {63'd0, en});
        write_reg(REG_CENTER_X,     {48'd0, cx});
        write_reg(REG_CENTER_Y,     {48'd0, cy});
        write_reg(REG_START_MIN_X,  {48'd0, mnx});
        write_reg(REG_START_MAX_X,  {48'd0, mxx});
        write_reg(REG_START_MIN_Y,  {48'd0, mny});
        write_reg(REG_START_MAX_Y,  {48'd0, mxy});
        cfg_we       <= 1'b0;
        cur_bindings  = binds;
        cur_cx        = cx;
        cur_cy        = cy;
    endtask

    task automatic run_random(input int count, input int pct);
        idle_pct = pct;
        repeat (count) send_item(random_item());
        drain_results();
    endtask

    initial begin
        sb = new();

        // Hold reset, once only.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset configuration: all bindings are zero, so
        // scan code zero hits every control bit; dead zone is 8191 around 32767.
        idle_pct = 20;
        send_item(make_item(REQ_STATUS,   7'd0,        16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_KEY_DOWN, 7'd0,        16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_STATUS,   7'd0,        16'd0,     16'd0,     2'd0, 1'b1, CLR_TAPS));
        send_item(make_item(REQ_KEY_UP,   7'd0,        16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_KEY_DOWN, CODE_UP,     16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_KEY_DOWN, CODE_DOWN,   16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_KEY_DOWN, CODE_LEFT,   16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_KEY_DOWN, CODE_RIGHT,  16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_KEY_DOWN, CODE_ENTER,  16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_KEY_DOWN, CODE_LSHIFT, 16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_KEY_DOWN, CODE_RSHIFT, 16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_STATUS,   7'd0,        16'd0,     16'd0,     2'd0, 1'b1, CLR_ALL));
        send_item(make_item(REQ_KEY_UP,   CODE_UP,     16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_KEY_UP,   CODE_LSHIFT, 16'd0,     16'd0,     2'd0, 1'b1, CLR_NONE));
        // Joystick at both extremes, then a failed read that must change nothing
        send_item(make_item(REQ_JOY,      7'd0,        16'd0,     16'd0,     2'd3, 1'b1, CLR_NONE));
        send_item(make_item(REQ_JOY,      7'd0,        16'hFFFF,  16'hFFFF,  2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_JOY,      7'd0,        16'd32767, 16'd32767, 2'd3, 1'b0, CLR_NONE));
        // Dead zone edges: just inside, then just outside
        send_item(make_item(REQ_JOY,      7'd0,        16'd40958, 16'd24576, 2'd0, 1'b1, CLR_TAPS));
        send_item(make_item(REQ_JOY,      7'd0,        16'd40959, 16'd24575, 2'd0, 1'b1, CLR_NONE));
        send_item(make_item(REQ_KEY_DOWN, 7'd127,      16'hFFFF,  16'hFFFF,  2'd3, 1'b1, CLR_CODE));
        send_item(make_item(REQ_STATUS,   7'd127,      16'hFFFF,  16'hFFFF,  2'd3, 1'b1, CLR_NONE));
        send_item(make_item(REQ_KEY_UP,   7'd127,      16'hFFFF,  16'hFFFF,  2'd3, 1'b0, CLR_ALL));
        drain_results();

        // Random phases on reset settings, then a run of different settings.
        run_random(250, 25);

        // Random in-range codes, ordinary ranges; no idling on this stretch.
        configure({$urandom, $urandom} & 64'h7F7F_7F7F_7F7F_7F7F, 1'b1,
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 30000)), 16'($urandom_range(35000, 65535)),
                  16'($urandom_range(0, 30000)), 16'($urandom_range(35000, 65535)));
        run_random(300, 0);

        // Extremes: no binding can match, joystick off, fully inverted ranges.
        configure(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, MIN_RST, MAX_RST,
                  MAX_RST, MIN_RST, MAX_RST, MIN_RST);
        run_random(250, 30);

        // Duplicate bindings, one byte above 127; joystick back on with an
        // inverted x range and an empty y range.
        configure({8'h50, 8'h50, 8'h80, 8'h7F, 8'h00, 8'h2A, 8'h1C, 8'h48}, 1'b1,
                  MAX_RST, MIN_RST, 16'd40000, 16'd20000, 16'd0, 16'd0);
        run_random(300, 15);

        // Degenerate range at the centre: the dead zone starts at zero.
        configure({$urandom, $urandom} & 64'h7F7F_7F7F_7F7F_7F7F, 1'b1,
                  CENTER_RST, CENTER_RST, CENTER_RST, CENTER_RST, CENTER_RST, CENTER_RST);
        run_random(300, 40);

        // Fully random settings, enable included; the final stretch has no idling.
        configure({$urandom, $urandom}, 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_random(300, 20);
        run_random(200, 0);

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (sb.clean()) begin
            $display("key_joystick_control_mapper_top regression: pass");
        end else begin
            $display("key_joystick_control_mapper_top regression: fail");
        end
        $finish;
    end

endmodule
